// ===== sv/pwa_pkg.sv =====
// ----------------------------------------------------------------------------
// pwa_pkg
// shared widths, register indexes and pipeline depths of the warp address unit
// ----------------------------------------------------------------------------
package pwa_pkg;

  localparam int COORD_BITS = 16;             // active bits of coordinates and sizes
  localparam int CoordW     = 16;             // port width of coordinate fields
  localparam int CoefW      = 32;             // one matrix coefficient
  localparam int CfgW       = 64;             // widest configuration register
  localparam int CfgIdxW    = 3;
  localparam int ProdW      = CoefW + COORD_BITS + 1;
  localparam int SumW       = ProdW + 2;
  localparam int MagW       = SumW - 1;
  localparam int QuoW       = 16;             // quotient bits kept
  localparam int FracShift  = 8;              // numerator scale to match the denominator
  localparam int RemW       = MagW + QuoW + 2;
  localparam int DivLat     = QuoW + 2;       // magnitude stage, setup stage, one per bit
  localparam int FrontLat   = 2;              // product stage, sum stage
  localparam int Latency    = FrontLat + DivLat + 1;

  typedef enum logic [CfgIdxW-1:0] {
    REG_X_ROW_GAINS       = 3'd0,
    REG_Y_ROW_GAINS       = 3'd1,
    REG_ROW_OFFSETS       = 3'd2,
    REG_PERSPECTIVE_TERMS = 3'd3,
    REG_IMAGE_SIZE        = 3'd4
  } cfg_reg_t;

endpackage

// ===== sv/pwa_front.sv =====
// ----------------------------------------------------------------------------
// pwa_front
// products and sums of the homography rows: two numerators and the denominator
// ----------------------------------------------------------------------------
module pwa_front (
  input  logic                               clk,
  input  logic [pwa_pkg::CoordW-1:0]         x,
  input  logic [pwa_pkg::CoordW-1:0]         y,
  input  logic [pwa_pkg::CfgW-1:0]           x_row_gains,
  input  logic [pwa_pkg::CfgW-1:0]           y_row_gains,
  input  logic [pwa_pkg::CfgW-1:0]           row_offsets,
  input  logic [pwa_pkg::CfgW-1:0]           perspective_terms,
  output logic signed [pwa_pkg::SumW-1:0]    num_x,
  output logic signed [pwa_pkg::SumW-1:0]    num_y,
  output logic signed [pwa_pkg::SumW-1:0]    den
);

  logic signed [pwa_pkg::COORD_BITS:0]   xs, ys;
  logic signed [pwa_pkg::ProdW-1:0]      p00, p01, p10, p11, p20, p21;
  logic signed [pwa_pkg::SumW-1:0]       off_x, off_y;

  assign xs = $signed({1'b0, x[pwa_pkg::COORD_BITS-1:0]});
  assign ys = $signed({1'b0, y[pwa_pkg::COORD_BITS-1:0]});

  // stage 1: six products, offsets aligned to 2^-24
  always_ff @(posedge clk) begin
    p00   <= $signed(x_row_gains[31:0])        * xs;
    p01   <= $signed(x_row_gains[63:32])       * ys;
    p10   <= $signed(y_row_gains[31:0])        * xs;
    p11   <= $signed(y_row_gains[63:32])       * ys;
    p20   <= $signed(perspective_terms[31:0])  * xs;
    p21   <= $signed(perspective_terms[63:32]) * ys;
    off_x <= pwa_pkg::SumW'($signed(row_offsets[31:0]))  <<< pwa_pkg::FracShift;
    off_y <= pwa_pkg::SumW'($signed(row_offsets[63:32])) <<< pwa_pkg::FracShift;
  end

  // stage 2: three-input sums, constant one is 2^32
  always_ff @(posedge clk) begin
    num_x <= pwa_pkg::SumW'(p00) + pwa_pkg::SumW'(p01) + off_x;
    num_y <= pwa_pkg::SumW'(p10) + pwa_pkg::SumW'(p11) + off_y;
    den   <= pwa_pkg::SumW'(64'sh1_0000_0000) + pwa_pkg::SumW'(p20) + pwa_pkg::SumW'(p21);
  end

endmodule

// ===== sv/pwa_divider.sv =====
// ----------------------------------------------------------------------------
// pwa_divider
// pipelined restoring divider, one quotient bit per stage, with overflow flag
// ----------------------------------------------------------------------------
module pwa_divider (
  input  logic                               clk,
  input  logic signed [pwa_pkg::SumW-1:0]    num,
  input  logic signed [pwa_pkg::SumW-1:0]    den,
  output logic [pwa_pkg::QuoW-1:0]           quo,
  output logic                               neg,
  output logic                               ovf
);

  localparam int QW = pwa_pkg::QuoW;
  localparam int RW = pwa_pkg::RemW;
  localparam int MW = pwa_pkg::MagW;

  logic signed [pwa_pkg::SumW-1:0] num_abs, den_abs;
  logic [MW-1:0]  n_mag, d_mag;
  logic           neg_a;
  logic [RW-1:0]  n_shift, d_limit;

  logic [RW-1:0]  rem  [0:QW];
  logic [MW-1:0]  dv   [0:QW];
  logic [QW-1:0]  qv   [0:QW];
  logic           negv [0:QW];
  logic           ovfv [0:QW];

  assign num_abs = num[pwa_pkg::SumW-1] ? -num : num;
  assign den_abs = den[pwa_pkg::SumW-1] ? -den : den;

  // magnitudes and result sign
  always_ff @(posedge clk) begin
    n_mag <= num_abs[MW-1:0];
    d_mag <= den_abs[MW-1:0];
    neg_a <= num[pwa_pkg::SumW-1] ^ den[pwa_pkg::SumW-1];
  end

  assign n_shift = RW'(n_mag) << pwa_pkg::FracShift;
  assign d_limit = RW'(d_mag) << QW;

  // quotient of 2^16 or more cannot be in range; zero denominator lands here too
  always_ff @(posedge clk) begin
    rem[0]  <= n_shift;
    dv[0]   <= d_mag;
    qv[0]   <= '0;
    negv[0] <= neg_a;
    ovfv[0] <= n_shift >= d_limit;
  end

  for (genvar k = 0; k < QW; k++) begin : g_bit
    logic [RW-1:0] d_sh;
    logic          ge;
    assign d_sh = RW'(dv[k]) << (QW - 1 - k);
    assign ge   = rem[k] >= d_sh;
    always_ff @(posedge clk) begin
      rem[k+1]  <= ge ? rem[k] - d_sh : rem[k];
      dv[k+1]   <= dv[k];
      qv[k+1]   <= {qv[k][QW-2:0], ge};
      negv[k+1] <= negv[k];
      ovfv[k+1] <= ovfv[k];
    end
  end

  assign quo = qv[QW];
  assign neg = negv[QW];
  assign ovf = ovfv[QW];

endmodule

// ===== sv/projective_warp_address_unit.sv =====
// ----------------------------------------------------------------------------
// projective_warp_address_unit
// inverse homography source address generator, nearest neighbour
// ----------------------------------------------------------------------------
//  channel   signals                                  direction  handshake
//  command   start, busy, dest_col, dest_row          in         start & !busy
//  result    done, src_col, src_row, in_range         out        done, one cycle
//  config    cfg_wr_en, cfg_index, cfg_data           in         cfg_wr_en
//
//  one item per cycle, every cycle; busy is never raised
//  the pipeline runs through products, sums, magnitudes, overflow setup,
//  16 divider stages (one quotient bit each) and the result register
//  the 16-stage divider sets the latency, not the rate
//  rst clears the valid pipeline and loads the identity matrix, size zero
//  the receiver cannot stall; every result beat shows for exactly one cycle
// ----------------------------------------------------------------------------
module projective_warp_address_unit (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [pwa_pkg::CoordW-1:0]    dest_col,
  input  logic [pwa_pkg::CoordW-1:0]    dest_row,
  input  logic                          cfg_wr_en,
  input  logic [pwa_pkg::CfgIdxW-1:0]   cfg_index,
  input  logic [pwa_pkg::CfgW-1:0]      cfg_data,
  output logic                          done,
  output logic [pwa_pkg::CoordW-1:0]    src_col,
  output logic [pwa_pkg::CoordW-1:0]    src_row,
  output logic                          in_range
);

  localparam int VLen = pwa_pkg::FrontLat + pwa_pkg::DivLat;

  // configuration registers
  logic [pwa_pkg::CfgW-1:0] x_row_gains, y_row_gains, row_offsets, perspective_terms;
  logic [31:0]              image_size;

  always_ff @(posedge clk) begin
    if (rst) begin
      x_row_gains       <= 64'h0000_0000_0100_0000;
      y_row_gains       <= 64'h0100_0000_0000_0000;
      row_offsets       <= '0;
      perspective_terms <= '0;
      image_size        <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        pwa_pkg::REG_X_ROW_GAINS:       x_row_gains       <= cfg_data;
        pwa_pkg::REG_Y_ROW_GAINS:       y_row_gains       <= cfg_data;
        pwa_pkg::REG_ROW_OFFSETS:       row_offsets       <= cfg_data;
        pwa_pkg::REG_PERSPECTIVE_TERMS: perspective_terms <= cfg_data;
        pwa_pkg::REG_IMAGE_SIZE:        image_size        <= cfg_data[31:0];
        default: ;  // unknown index: write dropped
      endcase
    end
  end

  // pipeline always moves, so an item enters every cycle
  assign busy = 1'b0;

  logic [VLen-1:0] vld;
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[VLen-2:0], start & ~busy};
    end
  end

  logic signed [pwa_pkg::SumW-1:0] num_x, num_y, den;

  pwa_front u_front (
    .clk               (clk),
    .x                 (dest_col),
    .y                 (dest_row),
    .x_row_gains       (x_row_gains),
    .y_row_gains       (y_row_gains),
    .row_offsets       (row_offsets),
    .perspective_terms (perspective_terms),
    .num_x             (num_x),
    .num_y             (num_y),
    .den               (den)
  );

  logic [pwa_pkg::QuoW-1:0] qx, qy;
  logic                     neg_x, neg_y, ovf_x, ovf_y;

  pwa_divider u_div_x (
    .clk (clk),
    .num (num_x),
    .den (den),
    .quo (qx),
    .neg (neg_x),
    .ovf (ovf_x)
  );

  pwa_divider u_div_y (
    .clk (clk),
    .num (num_y),
    .den (den),
    .quo (qy),
    .neg (neg_y),
    .ovf (ovf_y)
  );

  // range check: a negative value truncating to zero still counts as zero
  logic [pwa_pkg::QuoW-1:0] lim_w, lim_h;
  logic                     ok_x, ok_y, ok;

  assign lim_w = pwa_pkg::QuoW'(image_size[pwa_pkg::COORD_BITS-1:0]);
  assign lim_h = pwa_pkg::QuoW'(image_size[16 +: pwa_pkg::COORD_BITS]);
  assign ok_x  = !ovf_x && !(neg_x && qx != '0) && (qx < lim_w);
  assign ok_y  = !ovf_y && !(neg_y && qy != '0) && (qy < lim_h);
  assign ok    = ok_x && ok_y;

  // result register, outputs cleared between beats
  always_ff @(posedge clk) begin
    if (rst) begin
      done     <= 1'b0;
      in_range <= 1'b0;
      src_col  <= '0;
      src_row  <= '0;
    end else begin
      done     <= vld[VLen-1];
      in_range <= vld[VLen-1] && ok;
      src_col  <= (vld[VLen-1] && ok) ? pwa_pkg::CoordW'(qx) : '0;
      src_row  <= (vld[VLen-1] && ok) ? pwa_pkg::CoordW'(qy) : '0;
    end
  end

endmodule

// ===== sv/pwa_checker.sv =====
// ----------------------------------------------------------------------------
// pwa_checker
// port-level checks of the warp address unit, bound to the top level
// ----------------------------------------------------------------------------
module pwa_checker (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic                          busy,
  input  logic                          done,
  input  logic [pwa_pkg::CoordW-1:0]    src_col,
  input  logic [pwa_pkg::CoordW-1:0]    src_row,
  input  logic                          in_range
);

  // every result beat comes from a command a fixed latency earlier
  a_done_has_cmd: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, pwa_pkg::Latency))
    else $error("result beat without matching command");

  // out of range results carry zero coordinates
  a_zero_when_out: assert property (@(posedge clk) disable iff (rst)
    (done && !in_range) |-> (src_col == '0 && src_row == '0))
    else $error("out of range result with nonzero coordinates");

  // in_range only on a result beat
  a_flag_on_beat: assert property (@(posedge clk) disable iff (rst)
    in_range |-> done)
    else $error("in_range outside a result beat");

  // nothing comes out right after reset
  a_quiet_after_reset: assert property (@(posedge clk)
    $past(rst) |-> !done)
    else $error("result beat right after reset");

endmodule

bind projective_warp_address_unit pwa_checker u_pwa_checker (
  .clk      (clk),
  .rst      (rst),
  .start    (start),
  .busy     (busy),
  .done     (done),
  .src_col  (src_col),
  .src_row  (src_row),
  .in_range (in_range)
);

// ===== test/tb_projective_warp_address_unit.sv =====
// ----------------------------------------------------------------------------
// tb_projective_warp_address_unit
// checks the warp address unit against an in-bench homography predictor:
// directed corner cases, then randomized matrices, image sizes and pixel
// beats, with random gaps on the command side and scoreboarded result beats
// ----------------------------------------------------------------------------
module tb_projective_warp_address_unit;

  localparam int CycleLimit = 600000;
  localparam int MaxReports = 10;

  typedef struct packed {
    logic [pwa_pkg::CoordW-1:0] col;
    logic [pwa_pkg::CoordW-1:0] row;
  } pixel_t;

  typedef struct packed {
    logic [pwa_pkg::CoordW-1:0] col;
    logic [pwa_pkg::CoordW-1:0] row;
    logic                       hit;
  } source_t;

  logic                        clk;
  logic                        rst;
  logic                        start = 1'b0;
  logic                        busy;
  logic [pwa_pkg::CoordW-1:0]  dest_col = '0;
  logic [pwa_pkg::CoordW-1:0]  dest_row = '0;
  logic                        cfg_wr_en;
  logic [pwa_pkg::CfgIdxW-1:0] cfg_index;
  logic [pwa_pkg::CfgW-1:0]    cfg_data;
  logic                        done;
  logic [pwa_pkg::CoordW-1:0]  src_col;
  logic [pwa_pkg::CoordW-1:0]  src_row;
  logic                        in_range;

  projective_warp_address_unit u_top (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .busy     (busy),
    .dest_col (dest_col),
    .dest_row (dest_row),
    .cfg_wr_en(cfg_wr_en),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .done     (done),
    .src_col  (src_col),
    .src_row  (src_row),
    .in_range (in_range)
  );

  // shadow copy of the matrix and image size
  logic [63:0] x_gains, y_gains, offsets, persp;
  logic [31:0] img_size;

  pixel_t  pixel_queue[$];     // pixels waiting to be driven
  source_t source_queue[$];    // predicted source addresses, oldest first
  int      mismatches = 0;
  int      cycle_count = 0;
  bit      no_gaps;            // phase runs back to back
  bit      beat_taken = 1'b0;  // command beat accepted at the last rising edge
  int      gap_left = 0;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // appends a pixel to the driver's list
  function automatic void queue_pixel(pixel_t p);
    pixel_queue.insert(pixel_queue.size(), p);
  endfunction

  // truncated quotient num*256/den; zero return means out of range
  function automatic bit trunc_divide(longint num, longint den, logic [63:0] lim,
                                      output logic [63:0] q);
    logic [63:0] mag_n, mag_d;
    bit          neg;
    mag_n = (num < 0) ? 64'(-num) : 64'(num);
    mag_d = (den < 0) ? 64'(-den) : 64'(den);
    q     = (mag_n << 8) / mag_d;
    neg   = (num < 0) != (den < 0);
    if (neg && q != 0) return 1'b0;
    return q < lim;
  endfunction

  // maps a destination pixel to its nearest source pixel
  function automatic source_t warp_pixel(pixel_t p);
    longint      x, y, den, nx, ny;
    logic [63:0] qx, qy;
    source_t     r;
    x   = longint'(p.col);
    y   = longint'(p.row);
    den = (64'sd1 <<< 32) + longint'($signed(persp[31:0])) * x
          + longint'($signed(persp[63:32])) * y;
    nx  = longint'($signed(x_gains[31:0])) * x + longint'($signed(x_gains[63:32])) * y
          + longint'($signed(offsets[31:0])) * 256;
    ny  = longint'($signed(y_gains[31:0])) * x + longint'($signed(y_gains[63:32])) * y
          + longint'($signed(offsets[63:32])) * 256;
    r = '0;
    if (den != 0 && trunc_divide(nx, den, 64'(img_size[15:0]), qx)
                 && trunc_divide(ny, den, 64'(img_size[31:16]), qy)) begin
      r.col = qx[15:0];
      r.row = qy[15:0];
      r.hit = 1'b1;
    end
    return r;
  endfunction

  // command driver: new beat or gap at each falling edge
  always @(negedge clk) begin
    if (rst) begin
      start <= 1'b0;
      gap_left <= 0;
    end else if (!start || beat_taken) begin
      if (gap_left > 0 || pixel_queue.size() == 0) begin
        start <= 1'b0;
        if (gap_left > 0) gap_left <= gap_left - 1;
      end else begin
        pixel_t p;
        p = pixel_queue.pop_front();
        start    <= 1'b1;
        dest_col <= p.col;
        dest_row <= p.row;
        // mostly no gap, some short gaps, a few long ones
        if (!no_gaps) begin
          case ($urandom_range(0, 19))
            0, 1, 2, 3:  gap_left <= $urandom_range(1, 3);
            4:           gap_left <= $urandom_range(10, 40);
            default:     gap_left <= 0;
          endcase
        end
      end
    end
  end

  // monitor: predict on accepted commands, check result beats
  always @(posedge clk) begin
    beat_taken <= 1'b0;
    if (!rst) begin
      if (start && !busy) begin
        source_queue.insert(source_queue.size(), warp_pixel({dest_col, dest_row}));
        beat_taken <= 1'b1;
      end
      if (done) begin
        if (source_queue.size() == 0) begin
          mismatches++;
          if (mismatches <= MaxReports)
            $display("unexpected result beat: col %0d row %0d hit %0b",
                     src_col, src_row, in_range);
        end else begin
          source_t e;
          e = source_queue.pop_front();
          if (e.col !== src_col || e.row !== src_row || e.hit !== in_range) begin
            mismatches++;
            if (mismatches <= MaxReports)
              $display("mismatch: expected col %0d row %0d hit %0b, got %0d %0d %0b",
                       e.col, e.row, e.hit, src_col, src_row, in_range);
          end
        end
      end
    end
  end

  // run watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  // register write while idle; shadow follows the block's decode
  task automatic write_reg(logic [pwa_pkg::CfgIdxW-1:0] idx, logic [63:0] val);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      pwa_pkg::REG_X_ROW_GAINS:       x_gains  = val;
      pwa_pkg::REG_Y_ROW_GAINS:       y_gains  = val;
      pwa_pkg::REG_ROW_OFFSETS:       offsets  = val;
      pwa_pkg::REG_PERSPECTIVE_TERMS: persp    = val;
      pwa_pkg::REG_IMAGE_SIZE:        img_size = val[31:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // let every queued pixel go through and the pipe drain
  task automatic drain;
    while (pixel_queue.size() != 0 || source_queue.size() != 0 || start)
      @(posedge clk);
    repeat (pwa_pkg::Latency + 3) @(posedge clk);
  endtask

  function automatic pixel_t rand_pixel();
    pixel_t p;
    if ($urandom_range(0, 4) == 0) begin
      p.col = $urandom_range(0, 65535);
      p.row = $urandom_range(0, 65535);
    end else begin
      p.col = $urandom_range(0, 1100);
      p.row = $urandom_range(0, 1100);
    end
    return p;
  endfunction

  // Q8.24 gain near 1.0 or 0 with random perturbation
  function automatic logic [31:0] near_gain(bit unity);
    int d;
    d = $signed($urandom_range(0, 32'h0060_0000)) - 32'sh0030_0000;
    return (unity ? 32'h0100_0000 : 32'h0) + d;
  endfunction

  initial begin
    rst = 1'b1;
    cfg_wr_en = 1'b0;
    cfg_index = pwa_pkg::REG_X_ROW_GAINS;
    cfg_data = '0;
    no_gaps = 1'b0;
    // reset state of the block
    x_gains = 64'h0000_0000_0100_0000;
    y_gains = 64'h0100_0000_0000_0000;
    offsets = '0;
    persp = '0;
    img_size = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // reset config: size zero, nothing lands in range
    queue_pixel('{16'd0, 16'd0});
    queue_pixel('{16'hFFFF, 16'hFFFF});
    queue_pixel('{16'd5, 16'd7});
    drain();

    // identity, full size; field extremes
    no_gaps = 1'b1;
    write_reg(pwa_pkg::REG_IMAGE_SIZE, 64'hFFFF_FFFF);
    queue_pixel('{16'd0, 16'd0});
    queue_pixel('{16'hFFFE, 16'hFFFE});
    queue_pixel('{16'hFFFF, 16'h0000});
    queue_pixel('{16'h5555, 16'hAAAA});
    queue_pixel('{16'hAAAA, 16'h5555});
    drain();

    // small negative offset: quotient in (-1,0) truncates to zero, in range
    write_reg(pwa_pkg::REG_ROW_OFFSETS, 64'hFFFF_FFFF_FFFF_FFFF);
    queue_pixel('{16'd0, 16'd0});
    queue_pixel('{16'd3, 16'd3});
    drain();
    // write to an unused index is dropped
    write_reg(3'($urandom_range(5, 7)), 64'hDEAD_BEEF_0000_0000);
    queue_pixel('{16'd1, 16'd0});
    drain();

    // zero denominator: h20 = -0.5, x = 2 gives w = 0
    write_reg(pwa_pkg::REG_PERSPECTIVE_TERMS, 64'h0000_0000_8000_0000);
    queue_pixel('{16'd2, 16'd0});
    queue_pixel('{16'd1, 16'd9});
    queue_pixel('{16'd3, 16'd9});   // negative w
    drain();

    // extreme gains: overflow and negative results
    write_reg(pwa_pkg::REG_PERSPECTIVE_TERMS, 64'h0);
    write_reg(pwa_pkg::REG_X_ROW_GAINS, 64'h7FFF_FFFF_7FFF_FFFF);
    write_reg(pwa_pkg::REG_Y_ROW_GAINS, 64'h8000_0000_8000_0000);
    write_reg(pwa_pkg::REG_ROW_OFFSETS, 64'h7FFF_FFFF_8000_0000);
    queue_pixel('{16'd0, 16'd0});
    queue_pixel('{16'd1, 16'd1});
    queue_pixel('{16'hFFFF, 16'hFFFF});
    drain();

    // small image, size at 1x1
    write_reg(pwa_pkg::REG_X_ROW_GAINS, 64'h0000_0000_0100_0000);
    write_reg(pwa_pkg::REG_Y_ROW_GAINS, 64'h0100_0000_0000_0000);
    write_reg(pwa_pkg::REG_ROW_OFFSETS, 64'h0);
    write_reg(pwa_pkg::REG_IMAGE_SIZE, 64'h0001_0001);
    queue_pixel('{16'd0, 16'd0});
    queue_pixel('{16'd1, 16'd0});
    queue_pixel('{16'd0, 16'd1});
    drain();

    // random phases: mostly plausible warps, some raw register noise
    for (int ph = 0; ph < 12; ph++) begin
      no_gaps = (ph % 4 == 3);
      if (ph % 5 == 4) begin
        write_reg(pwa_pkg::REG_X_ROW_GAINS, {$urandom, $urandom});
        write_reg(pwa_pkg::REG_Y_ROW_GAINS, {$urandom, $urandom});
        write_reg(pwa_pkg::REG_ROW_OFFSETS, {$urandom, $urandom});
        write_reg(pwa_pkg::REG_PERSPECTIVE_TERMS, {$urandom, $urandom});
        write_reg(pwa_pkg::REG_IMAGE_SIZE, {32'h0, $urandom});
      end else begin
        write_reg(pwa_pkg::REG_X_ROW_GAINS, {near_gain(0), near_gain(1)});
        write_reg(pwa_pkg::REG_Y_ROW_GAINS, {near_gain(1), near_gain(0)});
        write_reg(pwa_pkg::REG_ROW_OFFSETS, {16'($urandom_range(0, 200)), 16'($urandom),
                                             16'($urandom_range(0, 200)), 16'($urandom)});
        // perspective terms around +-2^-14 per pixel
        write_reg(pwa_pkg::REG_PERSPECTIVE_TERMS,
                  {32'($signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000),
                   32'($signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000)});
        write_reg(pwa_pkg::REG_IMAGE_SIZE, {32'h0, 16'($urandom_range(1, 1200)),
                                            16'($urandom_range(1, 1200))});
      end
      for (int i = 0; i < 135; i++) queue_pixel(rand_pixel());
      drain();
    end

    if (mismatches == 0 && source_queue.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
